// ===== rtl/fpsc_pkg.sv =====
package fpsc_pkg;

    // delay counter width and derived limits
    localparam int DELAY_BITS = 18;
    localparam int TPU_W      = 16;
    localparam int TARGET_W   = TPU_W + 1;
    localparam int CMP_W      = (DELAY_BITS + 1 > TARGET_W) ? DELAY_BITS + 1 : TARGET_W;
    localparam logic [CMP_W-1:0] DELAY_MAX = CMP_W'((64'd1 << DELAY_BITS) - 64'd1);

    // reset values of the configuration registers
    localparam logic [TPU_W-1:0] TPU_RESET = 16'd50;

    // configuration register indexes (word addresses)
    typedef enum logic [1:0] {
        REG_TICKS_PER_US  = 2'd0,
        REG_CHECK_NSTATUS = 2'd1,
        REG_CHECK_CDONE   = 2'd2,
        REG_UNUSED        = 2'd3
    } reg_idx_t;

    // sequence result codes
    typedef enum logic [2:0] {
        ERR_NONE            = 3'd0,
        ERR_NSTATUS_START   = 3'd1,
        ERR_NSTATUS_LOW_CFG = 3'd2,
        ERR_CDONE_LOW_CFG   = 3'd3,
        ERR_CDONE_HIGH_CFG  = 3'd4,
        ERR_NSTATUS_HIGH_CFG= 3'd5,
        ERR_NSTATUS_END     = 3'd6,
        ERR_CDONE_END       = 3'd7
    } err_code_t;

    // result word bit positions
    localparam int OUT_NCONFIG = 0;
    localparam int OUT_DCLK    = 1;
    localparam int OUT_DATA    = 2;
    localparam int OUT_TAKEN   = 3;
    localparam int OUT_BUSY    = 4;
    localparam int OUT_FIN     = 5;
    localparam int OUT_ERR_LO  = 6;
    localparam int OUT_ERR_HI  = 8;

endpackage

// ===== rtl/fpga_passive_serial_config_loader.sv =====
// Passive serial configuration sequencer for an FPGA.
// Each transfer on the s_ channel is one tick of the pin sequencer: a start
// request, an optional bitstream byte (s_tuser marks it valid, s_tlast marks
// the final byte) and the sampled nSTATUS and CDONE levels. Each accepted
// tick gives exactly one transfer on the m_ channel with the driven nCONFIG,
// DCLK and DATA levels, byte_taken, busy, finished and the error code.
// The result is registered and appears in the cycle after the input transfer;
// one tick is taken per cycle while the receiver keeps up, with a single state
// update per tick. Delays are counted in ticks: ticks_per_us ticks per us.
// Bytes go out LSB first, two ticks per bit (DCLK low with DATA, then high).
// The APB port sets ticks_per_us, check_nstatus and check_cdone; write
// it only while no sequence runs and no result is pending.
// Reset (aresetn low, synchronous) returns the sequencer to idle with nCONFIG
// high, DCLK and DATA low, error code 0, and the result register empty.
// When the receiver stalls, the result is held in the output register and
// s_tready drops until it is taken; the sequencer does not advance meanwhile.
module fpga_passive_serial_config_loader (
    input  logic        aclk,
    input  logic        aresetn,
    // input ticks
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // start_req, bitstream_byte[7:0], nstatus_pin,
                                   // cdone_pin, zero fill
    input  logic        s_tuser,   // byte_valid
    input  logic        s_tlast,   // last_byte
    // results
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // nconfig_out, dclk_out, data_out, byte_taken,
                                   // busy_res, finished, error_code[2:0], zero fill
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    typedef enum logic [3:0] {
        PH_IDLE      = 4'd0,
        PH_START     = 4'd1,
        PH_NCFG_LOW  = 4'd2,
        PH_NCFG_HIGH = 4'd3,
        PH_SETTLE    = 4'd4,
        PH_WAIT_BYTE = 4'd5,
        PH_SHIFT     = 4'd6,
        PH_TAIL1     = 4'd7,
        PH_TAIL2     = 4'd8,
        PH_TAIL3     = 4'd9
    } phase_t;

    localparam int DB = fpsc_pkg::DELAY_BITS;
    localparam int CW = fpsc_pkg::CMP_W;

    // configuration registers
    logic [fpsc_pkg::TPU_W-1:0] tpu_reg;
    logic                       chk_ns_reg;
    logic                       chk_cd_reg;

    // sequencer state
    phase_t      phase_reg, phase_next;
    logic [DB-1:0] dcnt_reg, dcnt_next;
    logic [2:0]  bit_reg, bit_next;
    logic [7:0]  shift_reg, shift_next;
    logic        final_reg, final_next;
    logic        half_reg, half_next;
    logic        ncfg_reg, ncfg_next;
    logic        dclk_reg, dclk_next;
    logic        data_reg, data_next;
    fpsc_pkg::err_code_t lerr_reg, lerr_next;

    // result register
    logic        m_tvalid_reg;
    logic [15:0] m_tdata_reg;
    logic [15:0] res_next;

    // input fields
    logic       in_start, in_valid, in_last, in_nst, in_cdn;
    logic [7:0] in_byte;
    logic       s_xfer, cfg_wr;

    // delay compare
    logic [fpsc_pkg::TARGET_W-1:0] tgt_1us, tgt_2us, tgt_sel;
    logic [CW-1:0] limit, cnt_inc;
    logic          use_2us, dly_done;
    logic [DB-1:0] dcnt_adv;

    logic        taken, fin;
    fpsc_pkg::err_code_t err;
    fpsc_pkg::reg_idx_t  wr_idx, rd_idx;

    assign in_start = s_tdata[0];
    assign in_byte  = s_tdata[8:1];
    assign in_nst   = s_tdata[9];
    assign in_cdn   = s_tdata[10];
    assign in_valid = s_tuser;
    assign in_last  = s_tlast;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign s_xfer   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // delay target in ticks, clamped to the counter range
    assign tgt_1us = fpsc_pkg::TARGET_W'(tpu_reg);
    assign tgt_2us = {tpu_reg, 1'b0};
    assign use_2us = (phase_reg == PH_SETTLE);
    assign tgt_sel = use_2us ? tgt_2us : tgt_1us;
    assign limit   = (CW'(tgt_sel) < fpsc_pkg::DELAY_MAX) ? CW'(tgt_sel)
                                                           : fpsc_pkg::DELAY_MAX;
    assign cnt_inc  = CW'(dcnt_reg) + CW'(1);
    assign dly_done = (cnt_inc >= limit);
    assign dcnt_adv = dly_done ? '0 : cnt_inc[DB-1:0];

    // one tick of the sequencer
    always_comb begin
        phase_next = phase_reg;
        dcnt_next  = dcnt_reg;
        bit_next   = bit_reg;
        shift_next = shift_reg;
        final_next = final_reg;
        half_next  = half_reg;
        ncfg_next  = ncfg_reg;
        dclk_next  = dclk_reg;
        data_next  = data_reg;
        lerr_next  = lerr_reg;
        taken      = 1'b0;
        fin        = 1'b0;
        err        = fpsc_pkg::ERR_NONE;
        case (phase_reg)
            PH_START: begin
                dcnt_next = dcnt_adv;
                if (dly_done) begin
                    if (chk_ns_reg && !in_nst) begin
                        err = fpsc_pkg::ERR_NSTATUS_START;
                    end else begin
                        ncfg_next  = 1'b0;
                        phase_next = PH_NCFG_LOW;
                    end
                end
            end
            PH_NCFG_LOW: begin
                dcnt_next = dcnt_adv;
                if (dly_done) begin
                    if (chk_ns_reg && in_nst) begin
                        err = fpsc_pkg::ERR_NSTATUS_LOW_CFG;
                    end else if (chk_cd_reg && in_cdn) begin
                        err = fpsc_pkg::ERR_CDONE_LOW_CFG;
                    end else begin
                        ncfg_next  = 1'b1;
                        phase_next = PH_NCFG_HIGH;
                    end
                end
            end
            PH_NCFG_HIGH: begin
                dcnt_next = dcnt_adv;
                if (dly_done) begin
                    if (chk_cd_reg && in_cdn) begin
                        err = fpsc_pkg::ERR_CDONE_HIGH_CFG;
                    end else if (chk_ns_reg && !in_nst) begin
                        err = fpsc_pkg::ERR_NSTATUS_HIGH_CFG;
                    end else begin
                        phase_next = PH_SETTLE;
                    end
                end
            end
            PH_SETTLE: begin
                dcnt_next = dcnt_adv;
                if (dly_done) begin
                    phase_next = PH_WAIT_BYTE;
                end
            end
            PH_WAIT_BYTE: begin
                if (in_valid) begin
                    taken      = 1'b1;
                    shift_next = in_byte;
                    final_next = in_last;
                    bit_next   = 3'd0;
                    dclk_next  = 1'b0;
                    data_next  = in_byte[0];
                    half_next  = 1'b1;
                    phase_next = PH_SHIFT;
                end
            end
            PH_SHIFT: begin
                if (!half_reg) begin
                    dclk_next = 1'b0;
                    data_next = shift_reg[bit_reg];
                    half_next = 1'b1;
                end else begin
                    dclk_next = 1'b1;
                    half_next = 1'b0;
                    if (bit_reg == 3'd7) begin
                        bit_next   = 3'd0;
                        phase_next = final_reg ? PH_TAIL1 : PH_WAIT_BYTE;
                        dcnt_next  = '0;
                    end else begin
                        bit_next = bit_reg + 3'd1;
                    end
                end
            end
            PH_TAIL1: begin
                dcnt_next = dcnt_adv;
                if (dly_done) begin
                    dclk_next  = 1'b0;
                    phase_next = PH_TAIL2;
                end
            end
            PH_TAIL2: begin
                dcnt_next = dcnt_adv;
                if (dly_done) begin
                    dclk_next  = 1'b1;
                    phase_next = PH_TAIL3;
                end
            end
            PH_TAIL3: begin
                dcnt_next = dcnt_adv;
                if (dly_done) begin
                    dclk_next = 1'b0;
                    if (chk_ns_reg && !in_nst) begin
                        err = fpsc_pkg::ERR_NSTATUS_END;
                    end else if (chk_cd_reg && !in_cdn) begin
                        err = fpsc_pkg::ERR_CDONE_END;
                    end else begin
                        fin        = 1'b1;
                        lerr_next  = fpsc_pkg::ERR_NONE;
                        phase_next = PH_IDLE;
                    end
                end
            end
            default: begin
                // idle, and any unused code behaves as idle
                phase_next = PH_IDLE;
                if (in_start) begin
                    dclk_next  = 1'b0;
                    ncfg_next  = 1'b1;
                    dcnt_next  = '0;
                    bit_next   = 3'd0;
                    half_next  = 1'b0;
                    final_next = 1'b0;
                    lerr_next  = fpsc_pkg::ERR_NONE;
                    phase_next = PH_START;
                end
            end
        endcase

        // failed check ends the sequence, pins keep this tick's levels
        if (err != fpsc_pkg::ERR_NONE) begin
            lerr_next  = err;
            fin        = 1'b1;
            dcnt_next  = '0;
            phase_next = PH_IDLE;
        end

        res_next = '0;
        res_next[fpsc_pkg::OUT_NCONFIG] = ncfg_next;
        res_next[fpsc_pkg::OUT_DCLK]    = dclk_next;
        res_next[fpsc_pkg::OUT_DATA]    = data_next;
        res_next[fpsc_pkg::OUT_TAKEN]   = taken;
        res_next[fpsc_pkg::OUT_BUSY]    = (phase_next != PH_IDLE);
        res_next[fpsc_pkg::OUT_FIN]     = fin;
        res_next[fpsc_pkg::OUT_ERR_HI:fpsc_pkg::OUT_ERR_LO] = lerr_next;
    end

    // sequencer state advances once per input transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            dcnt_reg  <= '0;
            bit_reg   <= '0;
            shift_reg <= '0;
            final_reg <= 1'b0;
            half_reg  <= 1'b0;
            ncfg_reg  <= 1'b1;
            dclk_reg  <= 1'b0;
            data_reg  <= 1'b0;
            lerr_reg  <= fpsc_pkg::ERR_NONE;
        end else if (s_xfer) begin
            phase_reg <= phase_next;
            dcnt_reg  <= dcnt_next;
            bit_reg   <= bit_next;
            shift_reg <= shift_next;
            final_reg <= final_next;
            half_reg  <= half_next;
            ncfg_reg  <= ncfg_next;
            dclk_reg  <= dclk_next;
            data_reg  <= data_next;
            lerr_reg  <= lerr_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (s_xfer) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            m_tdata_reg <= res_next;
        end
    end

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign wr_idx = fpsc_pkg::reg_idx_t'(paddr[3:2]);
    assign rd_idx = fpsc_pkg::reg_idx_t'(paddr[3:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tpu_reg    <= fpsc_pkg::TPU_RESET;
            chk_ns_reg <= 1'b1;
            chk_cd_reg <= 1'b1;
        end else if (cfg_wr) begin
            case (wr_idx)
                fpsc_pkg::REG_TICKS_PER_US:  tpu_reg    <= pwdata[15:0];
                fpsc_pkg::REG_CHECK_NSTATUS: chk_ns_reg <= pwdata[0];
                fpsc_pkg::REG_CHECK_CDONE:   chk_cd_reg <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (rd_idx)
            fpsc_pkg::REG_TICKS_PER_US:  prdata = {16'd0, tpu_reg};
            fpsc_pkg::REG_CHECK_NSTATUS: prdata = {31'd0, chk_ns_reg};
            fpsc_pkg::REG_CHECK_CDONE:   prdata = {31'd0, chk_cd_reg};
            default:                     prdata = 32'd0;
        endcase
    end

endmodule

// ===== rtl/fpsc_checker.sv =====
module fpsc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // the end of a sequence leaves the sequencer idle
    a_fin_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[fpsc_pkg::OUT_FIN] |-> !m_tdata[fpsc_pkg::OUT_BUSY])
        else $error("finished while busy");

    // a byte is taken only while busy, on a low DCLK half
    a_taken: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[fpsc_pkg::OUT_TAKEN] |->
            m_tdata[fpsc_pkg::OUT_BUSY] && !m_tdata[fpsc_pkg::OUT_DCLK]
            && m_tdata[fpsc_pkg::OUT_NCONFIG])
        else $error("byte taken outside the shift window");

    // the error code is cleared for the whole of a running sequence
    a_busy_err: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[fpsc_pkg::OUT_BUSY] |->
            m_tdata[fpsc_pkg::OUT_ERR_HI:fpsc_pkg::OUT_ERR_LO] == fpsc_pkg::ERR_NONE)
        else $error("error code set while busy");

endmodule

bind fpga_passive_serial_config_loader fpsc_checker u_fpsc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
